// ----- rtl/psh_pkg.sv -----
package psh_pkg;

  localparam int MaxSources = 1024;
  localparam int CosDepth = 1024;
  localparam int CosBits = $clog2(CosDepth);
  localparam int SrcAw = $clog2(MaxSources);

  localparam logic [63:0] TwoPiQ30 = 64'd6746518852;
  localparam logic [63:0] OneQ30 = 64'd1073741824;

  typedef logic signed [17:0] cos_tab_t [CosDepth];

  typedef enum logic [2:0] {
    REG_SOURCE_COUNT = 3'd0,
    REG_ZOOM         = 3'd1,
    REG_WAVE_STEP    = 3'd2,
    REG_REF_WAVE     = 3'd3,
    REG_SRC_AMP      = 3'd4,
    REG_REF_AMP      = 3'd5
  } reg_idx_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_REF1, ST_REF2, ST_REF3, ST_REF4, ST_REF5,
    ST_RD, ST_SQX, ST_SQY, ST_SQZ, ST_SQS, ST_SQRT,
    ST_RMUL, ST_PH, ST_CS, ST_AMP, ST_DV0, ST_DIV, ST_ACC,
    ST_FIN1, ST_FIN2, ST_FIN3, ST_FIN4, ST_FIN5, ST_FIN6, ST_FIN7, ST_DONE
  } state_t;

  function automatic logic [63:0] quarter_cos(input logic [63:0] u);
    logic [63:0] theta;
    logic [63:0] th2;
    logic [63:0] term;
    logic signed [63:0] sum;
    theta = (u * TwoPiQ30) >> 32;
    th2 = (theta * theta) >> 30;
    term = OneQ30;
    sum = $signed(OneQ30);
    for (int n = 1; n <= 7; n++) begin
      term = ((term * th2) >> 30) / 64'((2 * n - 1) * (2 * n));
      if (n % 2 == 1) sum = sum - $signed(term);
      else sum = sum + $signed(term);
    end
    if (sum < 0) sum = 0;
    if (sum > $signed(OneQ30)) sum = $signed(OneQ30);
    return sum;
  endfunction

  function automatic cos_tab_t build_cos_tab();
    cos_tab_t t;
    logic [63:0] ph;
    logic [1:0] quad;
    logic [63:0] f;
    logic [63:0] u;
    logic signed [63:0] c;
    for (int k = 0; k < CosDepth; k++) begin
      ph = (64'(k) << 32) / CosDepth;
      quad = ph[31:30];
      f = ph & (OneQ30 - 64'd1);
      u = quad[0] ? OneQ30 - f : f;
      c = $signed((quarter_cos(u) + 64'd8192) >> 14);
      t[k] = (quad == 2'd1 || quad == 2'd2) ? 18'(-c) : 18'(c);
    end
    return t;
  endfunction

  localparam cos_tab_t CosTab = build_cos_tab();

endpackage

// ----- rtl/point_source_hologram_pixel_unit.sv -----
// Table write: accepted while idle, the block stays ready.
// Pixel: the result word sums n sources; each source passes through the
// square root and then the divider, all on one shared 32x32 multiplier and
// one add/compare step.
// Ready only when idle. Reset clears the registers to their defaults and
// the running extremes; the source table holds no reset value.
module point_source_hologram_pixel_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // src_index, src_x, src_y, src_z, row, col, zero pad
  input  logic [95:0]  s_tdata,
  // func, frame_start
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // intensity, frame_min, frame_max
  output logic [191:0] m_tdata,
  // saturated
  output logic         m_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [23:0]  cfg_data
);

  psh_pkg::state_t state, state_next;

  logic [10:0] source_count;
  logic [3:0]  zoom;
  logic [23:0] wave_step, ref_wave_step;
  logic [15:0] source_amplitude, ref_amplitude;

  logic [59:0] mem [psh_pkg::MaxSources];
  logic [59:0] mem_q;
  logic [10:0] k;
  logic [10:0] n;

  logic [9:0] row, col;
  logic frame_start;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;

  logic signed [31:0] a, b;
  logic sat;
  logic [41:0] v, res, bitm, s2;
  logic [4:0] cnt;
  logic [5:0] dcnt;
  logic [24:0] r, r_calc, rem;
  logic [39:0] dq;
  logic csign;
  logic [63:0] s;
  logic [127:0] acc;
  logic [63:0] running_min, running_max;

  logic [19:0] adx, ady, adz;
  logic signed [21:0] dx, dy;
  logic signed [17:0] cos_v;
  logic [16:0] cos_abs;
  logic [psh_pkg::CosBits-1:0] cos_idx;
  logic [42:0] trial;
  logic [25:0] rem2;
  logic geq;
  logic signed [33:0] term, a_sum, b_sum;
  logic [31:0] aa, bb;
  logic [63:0] inten;
  logic acc_hi;

  assign cfg_ready = 1'b1;
  assign s_tready = (state == psh_pkg::ST_IDLE);
  assign n = (source_count > 11'(psh_pkg::MaxSources)) ? 11'(psh_pkg::MaxSources) : source_count;

  psh_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));

  assign dx = $signed({2'b0, row, 8'd0}) - 22'(signed'(mem_q[19:0]));
  assign dy = $signed({2'b0, col, 8'd0}) - 22'(signed'(mem_q[39:20]));
  assign adx = dx[21] ? 20'(-dx) : dx[19:0];
  assign ady = dy[21] ? 20'(-dy) : dy[19:0];
  assign adz = mem_q[59] ? 20'(-signed'(mem_q[59:40])) : mem_q[59:40];

  always_comb begin
    cos_idx = mul_p[31:32-psh_pkg::CosBits];
    if (state == psh_pkg::ST_REF3) cos_idx = mul_p[23:24-psh_pkg::CosBits];
  end

  always_ff @(posedge clk) begin
    cos_v <= psh_pkg::CosTab[cos_idx];
  end

  assign cos_abs = cos_v[17] ? 17'(-cos_v) : cos_v[16:0];

  assign r_calc = (mul_p[24:0] < 25'd256) ? 25'd256 : mul_p[24:0];
  assign trial = {1'b0, res} + {1'b0, bitm};
  assign rem2 = {rem, dq[39]};
  assign geq = rem2 >= {1'b0, r};
  assign term = csign ? -$signed({1'b0, dq[32:0]}) : $signed({1'b0, dq[32:0]});
  assign a_sum = 34'(a) + term;
  assign b_sum = 34'(b) + term;
  assign aa = a[31] ? 32'(-a) : a;
  assign bb = b[31] ? 32'(-b) : b;
  assign acc_hi = (acc[127:112] != 16'd0);
  assign inten = acc_hi ? '1 : acc[111:48];

  always_comb begin
    state_next = state;
    case (state)
      psh_pkg::ST_IDLE: if (s_tvalid && s_tuser[0]) state_next = psh_pkg::ST_REF1;
      psh_pkg::ST_REF1: state_next = psh_pkg::ST_REF2;
      psh_pkg::ST_REF2: state_next = psh_pkg::ST_REF3;
      psh_pkg::ST_REF3: state_next = psh_pkg::ST_REF4;
      psh_pkg::ST_REF4: state_next = psh_pkg::ST_REF5;
      psh_pkg::ST_REF5: state_next = (n == 11'd0) ? psh_pkg::ST_FIN1 : psh_pkg::ST_RD;
      psh_pkg::ST_RD:   state_next = psh_pkg::ST_SQX;
      psh_pkg::ST_SQX:  state_next = psh_pkg::ST_SQY;
      psh_pkg::ST_SQY:  state_next = psh_pkg::ST_SQZ;
      psh_pkg::ST_SQZ:  state_next = psh_pkg::ST_SQS;
      psh_pkg::ST_SQS:  state_next = psh_pkg::ST_SQRT;
      psh_pkg::ST_SQRT: if (cnt == 5'd20) state_next = psh_pkg::ST_RMUL;
      psh_pkg::ST_RMUL: state_next = psh_pkg::ST_PH;
      psh_pkg::ST_PH:   state_next = psh_pkg::ST_CS;
      psh_pkg::ST_CS:   state_next = psh_pkg::ST_AMP;
      psh_pkg::ST_AMP:  state_next = psh_pkg::ST_DV0;
      psh_pkg::ST_DV0:  state_next = psh_pkg::ST_DIV;
      psh_pkg::ST_DIV:  if (dcnt == 6'd39) state_next = psh_pkg::ST_ACC;
      psh_pkg::ST_ACC:  state_next = (k + 11'd1 == n) ? psh_pkg::ST_FIN1 : psh_pkg::ST_RD;
      psh_pkg::ST_FIN1: state_next = psh_pkg::ST_FIN2;
      psh_pkg::ST_FIN2: state_next = psh_pkg::ST_FIN3;
      psh_pkg::ST_FIN3: state_next = psh_pkg::ST_FIN4;
      psh_pkg::ST_FIN4: state_next = psh_pkg::ST_FIN5;
      psh_pkg::ST_FIN5: state_next = psh_pkg::ST_FIN6;
      psh_pkg::ST_FIN6: state_next = psh_pkg::ST_FIN7;
      psh_pkg::ST_FIN7: state_next = psh_pkg::ST_DONE;
      psh_pkg::ST_DONE: if (!m_tvalid || m_tready) state_next = psh_pkg::ST_IDLE;
      default:          state_next = psh_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      psh_pkg::ST_REF1: begin mul_a = 32'(ref_wave_step); mul_b = 32'(col); end
      psh_pkg::ST_REF2: begin mul_a = {8'd0, mul_p[23:0]}; mul_b = 32'(zoom); end
      psh_pkg::ST_REF4: begin mul_a = 32'(ref_amplitude); mul_b = 32'(cos_abs); end
      psh_pkg::ST_SQX:  begin mul_a = 32'(adx); mul_b = 32'(adx); end
      psh_pkg::ST_SQY:  begin mul_a = 32'(ady); mul_b = 32'(ady); end
      psh_pkg::ST_SQZ:  begin mul_a = 32'(adz); mul_b = 32'(adz); end
      psh_pkg::ST_RMUL: begin mul_a = 32'(zoom); mul_b = res[31:0]; end
      psh_pkg::ST_PH:   begin mul_a = 32'(wave_step); mul_b = 32'(r_calc); end
      psh_pkg::ST_AMP:  begin mul_a = 32'(source_amplitude); mul_b = 32'(cos_abs); end
      psh_pkg::ST_FIN1: begin mul_a = aa; mul_b = aa; end
      psh_pkg::ST_FIN2: begin mul_a = bb; mul_b = bb; end
      psh_pkg::ST_FIN4: begin mul_a = s[31:0]; mul_b = s[31:0]; end
      psh_pkg::ST_FIN5: begin mul_a = s[31:0]; mul_b = s[63:32]; end
      psh_pkg::ST_FIN6: begin mul_a = s[63:32]; mul_b = s[63:32]; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == psh_pkg::ST_IDLE && s_tvalid && !s_tuser[0]) begin
      mem[s_tdata[psh_pkg::SrcAw-1:0]] <= s_tdata[69:10];
    end
    mem_q <= mem[k[psh_pkg::SrcAw-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      source_count <= 11'd6;
      zoom <= 4'd5;
      wave_step <= 24'd861751;
      ref_wave_step <= 24'd0;
      source_amplitude <= 16'd100;
      ref_amplitude <= 16'd10;
    end else if (cfg_valid) begin
      case (cfg_index)
        psh_pkg::REG_SOURCE_COUNT: source_count <= cfg_data[10:0];
        psh_pkg::REG_ZOOM:         zoom <= cfg_data[3:0];
        psh_pkg::REG_WAVE_STEP:    wave_step <= cfg_data;
        psh_pkg::REG_REF_WAVE:     ref_wave_step <= cfg_data;
        psh_pkg::REG_SRC_AMP:      source_amplitude <= cfg_data[15:0];
        psh_pkg::REG_REF_AMP:      ref_amplitude <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= psh_pkg::ST_IDLE;
      m_tvalid <= 1'b0;
      running_min <= '1;
      running_max <= '0;
    end else begin
      state <= state_next;
      if (state == psh_pkg::ST_DONE && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
        if (frame_start) begin
          running_min <= inten;
          running_max <= inten;
        end else begin
          if (inten < running_min) running_min <= inten;
          if (inten > running_max) running_max <= inten;
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      psh_pkg::ST_IDLE: begin
        row <= s_tdata[79:70];
        col <= s_tdata[89:80];
        frame_start <= s_tuser[1];
        sat <= 1'b0;
        k <= '0;
      end
      psh_pkg::ST_REF4: csign <= cos_v[17];
      psh_pkg::ST_REF5: begin
        a <= '0;
        if (!csign && mul_p[32:31] != 2'd0) begin
          b <= 32'sh7FFFFFFF;
          sat <= 1'b1;
        end else if (csign && mul_p[32:0] > 33'h080000000) begin
          b <= 32'sh80000000;
          sat <= 1'b1;
        end else begin
          b <= csign ? 32'(-mul_p[31:0]) : mul_p[31:0];
        end
      end
      psh_pkg::ST_SQY: s2 <= mul_p[41:0];
      psh_pkg::ST_SQZ: s2 <= s2 + mul_p[41:0];
      psh_pkg::ST_SQS: begin
        v <= s2 + mul_p[41:0];
        res <= '0;
        bitm <= 42'd1 << 40;
        cnt <= '0;
      end
      psh_pkg::ST_SQRT: begin
        cnt <= cnt + 5'd1;
        bitm <= bitm >> 2;
        if ({1'b0, v} >= trial) begin
          v <= v - trial[41:0];
          res <= (res >> 1) + bitm;
        end else begin
          res <= res >> 1;
        end
      end
      psh_pkg::ST_PH: r <= r_calc;
      psh_pkg::ST_AMP: csign <= cos_v[17];
      psh_pkg::ST_DV0: begin
        dq <= {mul_p[31:0], 8'd0};
        rem <= '0;
        dcnt <= '0;
      end
      psh_pkg::ST_DIV: begin
        dcnt <= dcnt + 6'd1;
        rem <= geq ? 25'(rem2 - {1'b0, r}) : rem2[24:0];
        dq <= {dq[38:0], geq};
      end
      psh_pkg::ST_ACC: begin
        k <= k + 11'd1;
        if (a_sum > 34'sh07FFFFFFF) a <= 32'sh7FFFFFFF;
        else if (a_sum < -34'sh080000000) a <= 32'sh80000000;
        else a <= a_sum[31:0];
        if (b_sum > 34'sh07FFFFFFF) b <= 32'sh7FFFFFFF;
        else if (b_sum < -34'sh080000000) b <= 32'sh80000000;
        else b <= b_sum[31:0];
        if (a_sum > 34'sh07FFFFFFF || a_sum < -34'sh080000000 ||
            b_sum > 34'sh07FFFFFFF || b_sum < -34'sh080000000) begin
          sat <= 1'b1;
        end
      end
      psh_pkg::ST_FIN2: s <= {mul_p[62:0], 1'b0};
      psh_pkg::ST_FIN3: s <= s + mul_p;
      psh_pkg::ST_FIN5: acc <= {64'd0, mul_p};
      psh_pkg::ST_FIN6: acc <= acc + ({64'd0, mul_p} << 33);
      psh_pkg::ST_FIN7: acc <= acc + {mul_p, 64'd0};
      psh_pkg::ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          m_tdata[63:0] <= inten;
          if (frame_start) begin
            m_tdata[127:64] <= inten;
            m_tdata[191:128] <= inten;
          end else begin
            m_tdata[127:64] <= (inten < running_min) ? inten : running_min;
            m_tdata[191:128] <= (inten > running_max) ? inten : running_max;
          end
          m_tuser <= sat | acc_hi;
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- rtl/psh_mul.sv -----
module psh_mul (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] p
);

  always_ff @(posedge clk) begin
    p <= {32'd0, a} * {32'd0, b};
  end

endmodule

// ----- rtl/psh_checker.sv -----
module psh_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic [1:0]   s_tuser,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [191:0] m_tdata
);

  a_busy_after_pixel: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser[0] |=> !s_tready)
    else $error("ready stayed high after a pixel word");

  a_write_keeps_ready: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !s_tuser[0] |=> s_tready)
    else $error("table write stalled the input");

  a_extremes_order: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[127:64] <= m_tdata[63:0]) && (m_tdata[63:0] <= m_tdata[191:128]))
    else $error("intensity outside the frame extremes");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output word changed while stalled");

endmodule

bind point_source_hologram_pixel_unit psh_checker u_psh_checker (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

// ----- verif/point_source_hologram_pixel_unit_tb.sv -----
module point_source_hologram_pixel_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 4000000;
  localparam int HoldCycles = 8000;
  localparam int ItemTarget = 580;

  typedef struct packed {
    logic [63:0] inten;
    logic [63:0] fmin;
    logic [63:0] fmax;
    logic        sat;
  } pixel_result_t;

  typedef struct {
    bit                  is_cfg;
    psh_pkg::reg_idx_t   ridx;
    logic [23:0]         rval;
    logic                func;
    logic [9:0]          idx;
    logic signed [19:0]  x;
    logic signed [19:0]  y;
    logic signed [19:0]  z;
    logic [9:0]          prow;
    logic [9:0]          pcol;
    logic                fs;
    bit                  typed;
    pixel_result_t       want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [95:0] s_tdata = '0;
  logic [1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [191:0] m_tdata;
  logic m_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [23:0] cfg_data = '0;

  point_source_hologram_pixel_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow registers, source table and running extremes of the predictor.
  logic [10:0] sh_count = 11'd6;
  logic [3:0]  sh_zoom = 4'd5;
  logic [23:0] sh_wave = 24'd861751;
  logic [23:0] sh_ref_wave = 24'd0;
  logic [15:0] sh_src_amp = 16'd100;
  logic [15:0] sh_ref_amp = 16'd10;
  int src_x_tab [1024];
  int src_y_tab [1024];
  int src_z_tab [1024];
  logic [63:0] run_min = '1;
  logic [63:0] run_max = '0;
  int cos_lut [1024];

  pixel_result_t intensity_q [$];
  int errors = 0;
  int items_sent = 0;
  bit hold_req = 0;
  longint cycles = 0;

  function automatic longint quarter_cosine(logic [63:0] u);
    logic [63:0] theta;
    logic [63:0] th2;
    logic [63:0] term;
    longint sum;
    theta = (u * 64'd6746518852) >> 32;
    th2 = (theta * theta) >> 30;
    term = 64'd1073741824;
    sum = 64'sd1073741824;
    for (int n = 1; n <= 7; n++) begin
      term = ((term * th2) >> 30) / 64'((2 * n - 1) * (2 * n));
      if (n % 2 == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    if (sum > 64'sd1073741824) sum = 64'sd1073741824;
    return sum;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint clamp_q16(longint v, inout bit sat);
    if (v > 64'sd2147483647) begin
      sat = 1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      sat = 1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic logic [63:0] mag64(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic pixel_result_t predict_pixel(logic [9:0] prow, logic [9:0] pcol,
                                                  logic fs);
    pixel_result_t res;
    bit sat;
    longint a;
    longint b;
    longint dx;
    longint dy;
    longint dz;
    longint num;
    longint term;
    logic [63:0] t;
    logic [63:0] r;
    logic [63:0] mag;
    logic [63:0] s;
    logic [127:0] p;
    int n;
    sat = 0;
    a = 0;
    t = 64'(sh_ref_wave) * 64'(pcol) * 64'(sh_zoom);
    b = clamp_q16(longint'(sh_ref_amp) * cos_lut[t[23:14]], sat);
    n = (sh_count > 11'd1024) ? 1024 : int'(sh_count);
    for (int k = 0; k < n; k++) begin
      dx = longint'(prow) * 256 - src_x_tab[k];
      dy = longint'(pcol) * 256 - src_y_tab[k];
      dz = src_z_tab[k];
      r = 64'(sh_zoom) * int_sqrt(64'(dx * dx + dy * dy + dz * dz));
      if (r < 256) r = 256;
      t = 64'(sh_wave) * r;
      num = longint'(sh_src_amp) * cos_lut[t[31:22]];
      mag = (mag64(num) << 8) / r;
      term = num < 0 ? -longint'(mag) : longint'(mag);
      a = clamp_q16(a + term, sat);
      b = clamp_q16(b + term, sat);
    end
    s = 2 * (mag64(a) * mag64(a)) + mag64(b) * mag64(b);
    p = {64'd0, s} * {64'd0, s};
    if (p[127:112] != 0) begin
      res.inten = '1;
      sat = 1;
    end else begin
      res.inten = p[111:48];
    end
    if (fs) begin
      run_min = res.inten;
      run_max = res.inten;
    end else begin
      if (res.inten < run_min) run_min = res.inten;
      if (res.inten > run_max) run_max = res.inten;
    end
    res.fmin = run_min;
    res.fmax = run_max;
    res.sat = sat;
    return res;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("tb: mismatch in %s: got %h, want %h", what, got, want);
    errors++;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic wait_quiet();
    while (intensity_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(psh_pkg::reg_idx_t ridx, logic [23:0] val);
    s_tvalid <= 1'b0;
    wait_quiet();
    cfg_valid <= 1'b1;
    cfg_index <= ridx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (ridx)
      psh_pkg::REG_SOURCE_COUNT: sh_count = val[10:0];
      psh_pkg::REG_ZOOM:         sh_zoom = val[3:0];
      psh_pkg::REG_WAVE_STEP:    sh_wave = val;
      psh_pkg::REG_REF_WAVE:     sh_ref_wave = val;
      psh_pkg::REG_SRC_AMP:      sh_src_amp = val[15:0];
      psh_pkg::REG_REF_AMP:      sh_ref_amp = val[15:0];
      default: ;
    endcase
  endtask

  task automatic send_word(stim_row_t w);
    int gap;
    pixel_result_t pr;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tdata <= {6'd0, w.pcol, w.prow, w.z, w.y, w.x, w.idx};
    s_tuser <= {w.fs, w.func};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    items_sent++;
    if (!w.func) begin
      src_x_tab[w.idx] = w.x;
      src_y_tab[w.idx] = w.y;
      src_z_tab[w.idx] = w.z;
    end else begin
      pr = predict_pixel(w.prow, w.pcol, w.fs);
      intensity_q.push_back(w.typed ? w.want : pr);
    end
  endtask

  function automatic stim_row_t cfg_row(psh_pkg::reg_idx_t ridx, logic [23:0] val);
    stim_row_t w;
    w = '{default: '0, ridx: psh_pkg::REG_SOURCE_COUNT};
    w.is_cfg = 1;
    w.ridx = ridx;
    w.rval = val;
    return w;
  endfunction

  function automatic stim_row_t src_row(logic [9:0] idx, logic [19:0] x, logic [19:0] y,
                                        logic [19:0] z);
    stim_row_t w;
    w = '{default: '0, ridx: psh_pkg::REG_SOURCE_COUNT};
    w.func = 1'b0;
    w.idx = idx;
    w.x = x;
    w.y = y;
    w.z = z;
    return w;
  endfunction

  function automatic stim_row_t pix_row(logic [9:0] prow, logic [9:0] pcol, logic fs,
                                        bit typed, pixel_result_t want);
    stim_row_t w;
    w = '{default: '0, ridx: psh_pkg::REG_SOURCE_COUNT};
    w.func = 1'b1;
    w.prow = prow;
    w.pcol = pcol;
    w.fs = fs;
    w.typed = typed;
    w.want = want;
    return w;
  endfunction

  function automatic logic [19:0] rand_coord();
    if ($urandom_range(0, 1)) return 20'($urandom);
    return 20'($urandom_range(0, 262143));
  endfunction

  function automatic stim_row_t rand_src(logic [9:0] idx);
    return src_row(idx, rand_coord(), rand_coord(), rand_coord());
  endfunction

  task automatic run_phase(int phase, int n_items);
    logic [10:0] cnt;
    int lim;
    pixel_result_t none;
    none = '0;
    case (phase)
      0: begin
        cnt = 11'd24;
        write_reg(psh_pkg::REG_ZOOM, 24'd15);
        write_reg(psh_pkg::REG_WAVE_STEP, 24'hFFFFFF);
        write_reg(psh_pkg::REG_REF_WAVE, 24'hFFFFFF);
        write_reg(psh_pkg::REG_SRC_AMP, 24'hFFFF);
        write_reg(psh_pkg::REG_REF_AMP, 24'hFFFF);
      end
      1: begin
        cnt = 11'd0;
        write_reg(psh_pkg::REG_ZOOM, 24'd0);
        write_reg(psh_pkg::REG_WAVE_STEP, 24'd0);
        write_reg(psh_pkg::REG_REF_WAVE, 24'd0);
        write_reg(psh_pkg::REG_SRC_AMP, 24'd0);
        write_reg(psh_pkg::REG_REF_AMP, 24'd0);
      end
      default: begin
        cnt = ($urandom_range(0, 9) < 7) ? 11'($urandom_range(0, 8))
                                          : 11'($urandom_range(9, 24));
        write_reg(psh_pkg::REG_ZOOM, 24'($urandom_range(1, 15)));
        write_reg(psh_pkg::REG_WAVE_STEP, 24'($urandom));
        write_reg(psh_pkg::REG_REF_WAVE,
                  ($urandom_range(0, 3) == 0) ? 24'd0 : 24'($urandom));
        write_reg(psh_pkg::REG_SRC_AMP, 24'($urandom_range(0, 65535)));
        write_reg(psh_pkg::REG_REF_AMP, 24'($urandom_range(0, 65535)));
      end
    endcase
    write_reg(psh_pkg::REG_SOURCE_COUNT, 24'(cnt));
    if (phase == 2) hold_req = 1;
    for (int k = 0; k < int'(cnt); k++) send_word(rand_src(10'(k)));
    lim = n_items - int'(cnt);
    for (int k = 0; k < lim; k++) begin
      if ($urandom_range(0, 3) == 0) send_word(rand_src(10'($urandom_range(0, 1023))));
      else send_word(pix_row(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
                             $urandom_range(0, 9) == 0, 0, none));
    end
  endtask

  // Receiver: random back-pressure, plus one long hold on request.
  initial begin
    wait (!rst);
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_req = 0;
      end else if ($urandom_range(0, 9) < 7) begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end else begin
        m_tready <= 1'b0;
        if ($urandom_range(0, 9) == 0) repeat ($urandom_range(30, 80)) @(posedge clk);
        else repeat ($urandom_range(1, 3)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    pixel_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (intensity_q.size() == 0) begin
        report("unexpected word", m_tdata[63:0], '0);
      end else begin
        want = intensity_q.pop_front();
        if (m_tdata[63:0] !== want.inten) report("intensity", m_tdata[63:0], want.inten);
        if (m_tdata[127:64] !== want.fmin) report("frame_min", m_tdata[127:64], want.fmin);
        if (m_tdata[191:128] !== want.fmax)
          report("frame_max", m_tdata[191:128], want.fmax);
        if (m_tuser !== want.sat) report("saturated", 64'(m_tuser), 64'(want.sat));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    stim_row_t dir_tab [$];
    pixel_result_t all_sat;
    pixel_result_t all_zero;
    int phase;
    logic [63:0] ph;
    logic [63:0] f;
    logic [63:0] u;
    int c;
    for (int k = 0; k < 1024; k++) begin
      ph = 64'(k) << 22;
      f = ph & 64'h3FFFFFFF;
      u = ph[30] ? 64'd1073741824 - f : f;
      c = int'((quarter_cosine(u) + 8192) >>> 14);
      cos_lut[k] = (ph[31:30] == 2'd1 || ph[31:30] == 2'd2) ? -c : c;
    end
    all_sat = '{inten: '1, fmin: '1, fmax: '1, sat: 1'b1};
    all_zero = '0;

    // With zoom zero the distance clamps to one and full amplitude saturates A and B.
    dir_tab.push_back(cfg_row(psh_pkg::REG_SOURCE_COUNT, 24'd1));
    dir_tab.push_back(cfg_row(psh_pkg::REG_ZOOM, 24'd0));
    dir_tab.push_back(cfg_row(psh_pkg::REG_WAVE_STEP, 24'd0));
    dir_tab.push_back(cfg_row(psh_pkg::REG_SRC_AMP, 24'hFFFF));
    dir_tab.push_back(cfg_row(psh_pkg::REG_REF_AMP, 24'd0));
    dir_tab.push_back(src_row(10'd0, 20'h7FFFF, 20'h80000, 20'h80000));
    dir_tab.push_back(pix_row(10'd0, 10'd0, 1'b1, 1, all_sat));
    dir_tab.push_back(pix_row(10'd1023, 10'd1023, 1'b0, 1, all_sat));
    dir_tab.push_back(cfg_row(psh_pkg::REG_SRC_AMP, 24'd0));
    dir_tab.push_back(pix_row(10'd512, 10'd3, 1'b1, 1, all_zero));
    dir_tab.push_back(cfg_row(psh_pkg::REG_SOURCE_COUNT, 24'd0));
    dir_tab.push_back(pix_row(10'd1023, 10'd0, 1'b0, 1, all_zero));
    dir_tab.push_back(cfg_row(psh_pkg::REG_SOURCE_COUNT, 24'd3));
    dir_tab.push_back(cfg_row(psh_pkg::REG_ZOOM, 24'd5));
    dir_tab.push_back(cfg_row(psh_pkg::REG_WAVE_STEP, 24'd861751));
    dir_tab.push_back(cfg_row(psh_pkg::REG_SRC_AMP, 24'd100));
    dir_tab.push_back(cfg_row(psh_pkg::REG_REF_AMP, 24'd10));
    dir_tab.push_back(cfg_row(psh_pkg::REG_REF_WAVE, 24'd123457));
    dir_tab.push_back(src_row(10'd1, 20'd0, 20'd0, 20'd0));
    dir_tab.push_back(src_row(10'd2, 20'h80000, 20'h7FFFF, 20'h7FFFF));
    dir_tab.push_back(src_row(10'd1023, 20'hFFFFF, 20'd1, 20'h00100));
    dir_tab.push_back(pix_row(10'd0, 10'd0, 1'b1, 0, all_zero));
    dir_tab.push_back(pix_row(10'd1023, 10'd1023, 1'b0, 0, all_zero));
    dir_tab.push_back(pix_row(10'd0, 10'd1023, 1'b0, 0, all_zero));
    dir_tab.push_back(pix_row(10'd1023, 10'd0, 1'b0, 0, all_zero));
    dir_tab.push_back(pix_row(10'h2AA, 10'h155, 1'b0, 0, all_zero));
    dir_tab.push_back(cfg_row(psh_pkg::REG_REF_AMP, 24'hFFFF));
    dir_tab.push_back(cfg_row(psh_pkg::REG_REF_WAVE, 24'd0));
    dir_tab.push_back(pix_row(10'd5, 10'd0, 1'b1, 0, all_zero));

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) write_reg(dir_tab[i].ridx, dir_tab[i].rval);
      else send_word(dir_tab[i]);
    end

    phase = 0;
    while (items_sent < ItemTarget) begin
      run_phase(phase, 60);
      phase++;
    end

    s_tvalid <= 1'b0;
    while (intensity_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/psh_pkg.sv
rtl/psh_mul.sv
rtl/point_source_hologram_pixel_unit.sv
rtl/psh_checker.sv
verif/point_source_hologram_pixel_unit_tb.sv
